/* sv/mptd_pkg.sv */
// ----------------------------------------------------------------------------
// Multi-pin time debouncer package
// Shared types and constants for the debouncer, its evaluator and its event
// queue.
// ----------------------------------------------------------------------------
package mptd_pkg;

   localparam int PIN_COUNT    = 16;
   localparam int TIME_BITS    = 32;
   localparam int PIN_IDX_BITS = $clog2(PIN_COUNT);
   localparam int CFG_BITS     = 16;
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_ADDR_BITS = 4;

   localparam logic [CFG_BITS-1:0] DEBOUNCE_RESET = 16'd50;

   // Request action codes.
   localparam logic ACT_DEBOUNCE = 1'b0;
   localparam logic ACT_ARM      = 1'b1;

   // Register indexes, taken from paddr[3:2].
   typedef enum logic [1:0] {
      CSR_ENABLED,
      CSR_ACTIVE_LOW,
      CSR_BUTTON,
      CSR_DEBOUNCE
   } csr_reg_type;

   // Everything the event queue needs from one evaluated sample.
   typedef struct packed {
      logic [PIN_COUNT-1:0] fire;
      logic [PIN_COUNT-1:0] active;
      logic [PIN_COUNT-1:0] button;
   } event_set_type;

endpackage

/* sv/mptd_pin_eval.sv */
// ----------------------------------------------------------------------------
// Debouncer pin evaluator
// Works out, for all pins in parallel, the next raw, stable and change-time
// state of one request and which pins produce an event.
// ----------------------------------------------------------------------------
module mptd_pin_eval (
   input  logic                                    action,
   input  logic [mptd_pkg::PIN_COUNT-1:0]          pin_levels,
   input  logic [mptd_pkg::TIME_BITS-1:0]          now_ms,
   input  logic [mptd_pkg::PIN_COUNT-1:0]          arm_mask,
   input  logic [mptd_pkg::PIN_COUNT-1:0]          enabled_mask,
   input  logic [mptd_pkg::PIN_COUNT-1:0]          active_low_mask,
   input  logic [mptd_pkg::PIN_COUNT-1:0]          button_mask,
   input  logic [mptd_pkg::CFG_BITS-1:0]           debounce_time,
   input  logic [mptd_pkg::PIN_COUNT-1:0]          raw_active,
   input  logic [mptd_pkg::PIN_COUNT-1:0]          stable_active,
   input  logic [mptd_pkg::TIME_BITS-1:0]          change_time [mptd_pkg::PIN_COUNT],
   output logic [mptd_pkg::PIN_COUNT-1:0]          raw_next,
   output logic [mptd_pkg::PIN_COUNT-1:0]          stable_next,
   output logic [mptd_pkg::TIME_BITS-1:0]          change_next [mptd_pkg::PIN_COUNT],
   output mptd_pkg::event_set_type                 events
);

   logic [mptd_pkg::PIN_COUNT-1:0] active;
   logic [mptd_pkg::TIME_BITS-1:0] limit;

   assign active = pin_levels ^ active_low_mask;
   assign limit  = mptd_pkg::TIME_BITS'(debounce_time);

   always_comb begin
      logic [mptd_pkg::TIME_BITS-1:0] stamp;
      logic [mptd_pkg::TIME_BITS-1:0] elapsed;
      raw_next      = raw_active;
      stable_next   = stable_active;
      events.fire   = '0;
      events.active = active;
      events.button = button_mask;
      for (int p = 0; p < mptd_pkg::PIN_COUNT; p++) begin
         stamp   = (active[p] != raw_active[p]) ? now_ms : change_time[p];
         elapsed = now_ms - stamp;
         change_next[p] = change_time[p];
         if (action == mptd_pkg::ACT_ARM) begin
            if (arm_mask[p]) begin
               raw_next[p]    = active[p];
               stable_next[p] = active[p];
               change_next[p] = now_ms;
            end
         end else if (enabled_mask[p]) begin
            raw_next[p]    = active[p];
            change_next[p] = stamp;
            if (active[p] != stable_active[p] && elapsed >= limit) begin
               stable_next[p] = active[p];
               events.fire[p] = 1'b1;
            end
         end
      end
   end

endmodule

/* sv/mptd_event_queue.sv */
// ----------------------------------------------------------------------------
// Debouncer event queue
// Holds the events of one sample and hands them out one per cycle while
// rsp_stall is low, lowest pin first, through a registered response stage.
// ----------------------------------------------------------------------------
module mptd_event_queue (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 load,
   input  mptd_pkg::event_set_type              events,
   output logic                                 load_ok,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [mptd_pkg::PIN_IDX_BITS-1:0]    rsp_event_pin,
   output logic                                 rsp_event_active,
   output logic                                 rsp_is_button,
   output logic                                 rsp_last
);

   logic [mptd_pkg::PIN_COUNT-1:0]    pend_mask_ff, pend_mask_in;
   logic [mptd_pkg::PIN_COUNT-1:0]    pend_active_ff, pend_button_ff;
   logic [mptd_pkg::PIN_COUNT-1:0]    low_onehot, remaining;
   logic [mptd_pkg::PIN_IDX_BITS-1:0] low_idx;
   logic                              issue;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [mptd_pkg::PIN_IDX_BITS-1:0] pin_ff;
   logic                              active_ff, button_ff, last_ff;

   assign low_onehot = pend_mask_ff & (~pend_mask_ff + 1'b1);
   assign remaining  = pend_mask_ff & ~low_onehot;

   always_comb begin
      low_idx = '0;
      for (int p = 0; p < mptd_pkg::PIN_COUNT; p++) begin
         if (low_onehot[p]) begin
            low_idx = low_idx | mptd_pkg::PIN_IDX_BITS'(p);
         end
      end
   end

   assign issue = (|pend_mask_ff) && (!rsp_valid_ff || !rsp_stall);

   // A new sample may load when no event is pending or the last pending event leaves this cycle.
   assign load_ok = (pend_mask_ff == '0) || (issue && remaining == '0);

   always_comb begin
      pend_mask_in = pend_mask_ff;
      if (load) begin
         pend_mask_in = events.fire;
      end else if (issue) begin
         pend_mask_in = remaining;
      end
   end

   assign rsp_valid_in = issue || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_mask_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_mask_ff <= pend_mask_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         pend_active_ff <= events.active;
         pend_button_ff <= events.button;
      end
      if (issue) begin
         pin_ff    <= low_idx;
         active_ff <= |(pend_active_ff & low_onehot);
         button_ff <= |(pend_button_ff & low_onehot);
         last_ff   <= (remaining == '0);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_event_pin    = pin_ff;
   assign rsp_event_active = active_ff;
   assign rsp_is_button    = button_ff;
   assign rsp_last         = last_ff;

endmodule

/* sv/multi_pin_time_debouncer.sv */
// ----------------------------------------------------------------------------
// Multi-pin time debouncer
// Debounces sixteen pins against a millisecond time stamp and reports each
// change of a debounced pin as an event.
// ----------------------------------------------------------------------------
// Usage: each request carries a sample of the sixteen pin levels, the current
// millisecond time and an action. A debounce request updates the per-pin state
// and yields zero to sixteen events, lowest pin first, the final one marked
// with rsp_last. An arm request loads the state of the pins in req_arm_mask
// from the sample and yields no event.
// A request is taken into an input register and evaluated for all pins at
// once; its events are loaded into the event queue's pending mask and leave
// through a registered response stage. Throughput: one request per cycle
// while it yields at most one event and rsp_stall is low; a request with
// several events holds the event queue until its last event is issued, since
// the response register carries one event per cycle. Arm requests pass even
// while events of an earlier sample are still queued. When rsp_stall is high
// the response holds; once the input register holds a debounce request that
// the queue cannot take, req_stall rises. Reset clears the masks, sets the
// debounce time to 50 ms and clears all pin state and change times.
// ----------------------------------------------------------------------------
module multi_pin_time_debouncer (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_action,
   input  logic [15:0]                          req_pin_levels,
   input  logic [31:0]                          req_now_ms,
   input  logic [15:0]                          req_arm_mask,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [3:0]                           rsp_event_pin,
   output logic                                 rsp_event_active,
   output logic                                 rsp_is_button,
   output logic                                 rsp_last,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [mptd_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [mptd_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic [mptd_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                 csr_pready
);

   // Configuration registers.
   logic [mptd_pkg::PIN_COUNT-1:0] enabled_ff, active_low_ff, button_ff;
   logic [mptd_pkg::CFG_BITS-1:0]  debounce_ff;
   logic                           csr_write;
   mptd_pkg::csr_reg_type          csr_reg;

   // Input register.
   logic                           in_valid_ff, in_valid_in;
   logic                           in_action_ff;
   logic [mptd_pkg::PIN_COUNT-1:0] in_levels_ff, in_arm_ff;
   logic [mptd_pkg::TIME_BITS-1:0] in_now_ff;
   logic                           req_take, in_take;

   // Pin state.
   logic [mptd_pkg::PIN_COUNT-1:0] raw_ff, raw_in, stable_ff, stable_in;
   logic [mptd_pkg::TIME_BITS-1:0] change_ff [mptd_pkg::PIN_COUNT];
   logic [mptd_pkg::TIME_BITS-1:0] change_in [mptd_pkg::PIN_COUNT];

   mptd_pkg::event_set_type        events;
   logic                           load_ok;
   logic                           queue_load;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_reg    = mptd_pkg::csr_reg_type'(csr_paddr[3:2]);

   always_comb begin
      unique case (csr_reg)
         mptd_pkg::CSR_ENABLED:    csr_prdata = mptd_pkg::CSR_DATA_BITS'(enabled_ff);
         mptd_pkg::CSR_ACTIVE_LOW: csr_prdata = mptd_pkg::CSR_DATA_BITS'(active_low_ff);
         mptd_pkg::CSR_BUTTON:     csr_prdata = mptd_pkg::CSR_DATA_BITS'(button_ff);
         mptd_pkg::CSR_DEBOUNCE:   csr_prdata = mptd_pkg::CSR_DATA_BITS'(debounce_ff);
         default:                  csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff    <= '0;
         active_low_ff <= '0;
         button_ff     <= '0;
         debounce_ff   <= mptd_pkg::DEBOUNCE_RESET;
      end else if (csr_write) begin
         unique case (csr_reg)
            mptd_pkg::CSR_ENABLED:    enabled_ff    <= csr_pwdata[15:0];
            mptd_pkg::CSR_ACTIVE_LOW: active_low_ff <= csr_pwdata[15:0];
            mptd_pkg::CSR_BUTTON:     button_ff     <= csr_pwdata[15:0];
            mptd_pkg::CSR_DEBOUNCE:   debounce_ff   <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   // An arm request never produces events, so it need not wait for the queue.
   assign in_take     = in_valid_ff && (in_action_ff == mptd_pkg::ACT_ARM || load_ok);
   assign req_stall   = in_valid_ff && !in_take;
   assign req_take    = req_valid && !req_stall;
   assign in_valid_in = req_take || (in_valid_ff && !in_take);
   assign queue_load  = in_take && in_action_ff == mptd_pkg::ACT_DEBOUNCE;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_action_ff <= req_action;
         in_levels_ff <= req_pin_levels;
         in_now_ff    <= req_now_ms;
         in_arm_ff    <= req_arm_mask;
      end
   end

   mptd_pin_eval u_pin_eval (
      .action          (in_action_ff),
      .pin_levels      (in_levels_ff),
      .now_ms          (in_now_ff),
      .arm_mask        (in_arm_ff),
      .enabled_mask    (enabled_ff),
      .active_low_mask (active_low_ff),
      .button_mask     (button_ff),
      .debounce_time   (debounce_ff),
      .raw_active      (raw_ff),
      .stable_active   (stable_ff),
      .change_time     (change_ff),
      .raw_next        (raw_in),
      .stable_next     (stable_in),
      .change_next     (change_in),
      .events          (events)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         raw_ff    <= '0;
         stable_ff <= '0;
         for (int p = 0; p < mptd_pkg::PIN_COUNT; p++) begin
            change_ff[p] <= '0;
         end
      end else if (in_take) begin
         raw_ff    <= raw_in;
         stable_ff <= stable_in;
         for (int p = 0; p < mptd_pkg::PIN_COUNT; p++) begin
            change_ff[p] <= change_in[p];
         end
      end
   end

   mptd_event_queue u_event_queue (
      .clock            (clock),
      .reset            (reset),
      .load             (queue_load),
      .events           (events),
      .load_ok          (load_ok),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_event_pin    (rsp_event_pin),
      .rsp_event_active (rsp_event_active),
      .rsp_is_button    (rsp_is_button),
      .rsp_last         (rsp_last)
   );

endmodule

/* sv/mptd_checker.sv */
// ----------------------------------------------------------------------------
// Debouncer port checker
// Watches the ports of the debouncer for reset, response, ordering and register-port rules.
// ----------------------------------------------------------------------------
module mptd_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [3:0] rsp_event_pin,
   input logic       rsp_last,
   input logic       csr_pready
);

   // No response may be shown right after reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // A stalled response stays valid.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response dropped while stalled");

   // Events of one sample follow without a gap, in ascending pin order.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last |=>
         rsp_valid && rsp_event_pin > $past(rsp_event_pin))
      else $error("events of one sample not contiguous or not ascending");

   // The register port never inserts wait states.
   assert property (@(posedge clock) disable iff (reset) csr_pready)
      else $error("register port not ready");

endmodule

bind multi_pin_time_debouncer mptd_checker u_mptd_checker (.*);

/* verif/debounce_event_checker.sv */
// ----------------------------------------------------------------------------
// Debounce event checker
// Watches the request, response and register ports of the debouncer, keeps
// its own copy of the pin state and settings, predicts the events of every
// accepted request and compares each accepted response with the oldest one.
// ----------------------------------------------------------------------------
module debounce_event_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_stall,
   input  logic                                 req_action,
   input  logic [15:0]                          req_pin_levels,
   input  logic [31:0]                          req_now_ms,
   input  logic [15:0]                          req_arm_mask,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   input  logic [3:0]                           rsp_event_pin,
   input  logic                                 rsp_event_active,
   input  logic                                 rsp_is_button,
   input  logic                                 rsp_last,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [mptd_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [mptd_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   input  logic                                 csr_pready,
   output int                                   mismatch_count,
   output int                                   events_outstanding
);

   typedef struct packed {
      logic [mptd_pkg::PIN_IDX_BITS-1:0] pin;
      logic                              active;
      logic                              button;
      logic                              last;
   } pin_event_type;

   logic [mptd_pkg::PIN_COUNT-1:0] enabled_cfg;
   logic [mptd_pkg::PIN_COUNT-1:0] active_low_cfg;
   logic [mptd_pkg::PIN_COUNT-1:0] button_cfg;
   logic [mptd_pkg::CFG_BITS-1:0]  debounce_cfg;

   logic [mptd_pkg::PIN_COUNT-1:0] raw_state;
   logic [mptd_pkg::PIN_COUNT-1:0] stable_state;
   logic [mptd_pkg::TIME_BITS-1:0] changed_at [mptd_pkg::PIN_COUNT];

   pin_event_type pending_events[$];

   task automatic report_mismatch(input string what);
      $display("mismatch: %s", what);
      mismatch_count++;
   endtask

   // Updates the pin state for one request and queues the events it causes.
   function automatic void debounce_sample(input logic action,
                                           input logic [15:0] levels,
                                           input logic [31:0] now,
                                           input logic [15:0] arm);
      logic [mptd_pkg::PIN_COUNT-1:0] corrected;
      logic [mptd_pkg::PIN_COUNT-1:0] fired;
      logic [mptd_pkg::TIME_BITS-1:0] elapsed;
      pin_event_type ev;
      corrected = levels ^ active_low_cfg;
      fired = '0;
      if (action == mptd_pkg::ACT_ARM) begin
         for (int p = 0; p < mptd_pkg::PIN_COUNT; p++) begin
            if (arm[p]) begin
               raw_state[p] = corrected[p];
               stable_state[p] = corrected[p];
               changed_at[p] = now;
            end
         end
      end else begin
         for (int p = 0; p < mptd_pkg::PIN_COUNT; p++) begin
            if (enabled_cfg[p]) begin
               if (corrected[p] != raw_state[p]) begin
                  raw_state[p] = corrected[p];
                  changed_at[p] = now;
               end
               elapsed = now - changed_at[p];
               if (corrected[p] != stable_state[p] &&
                   elapsed >= {{(mptd_pkg::TIME_BITS-mptd_pkg::CFG_BITS){1'b0}},
                               debounce_cfg}) begin
                  stable_state[p] = corrected[p];
                  fired[p] = 1'b1;
               end
            end
         end
         // The highest fired pin carries the last flag.
         for (int p = 0; p < mptd_pkg::PIN_COUNT; p++) begin
            if (fired[p]) begin
               ev.pin = mptd_pkg::PIN_IDX_BITS'(p);
               ev.active = corrected[p];
               ev.button = button_cfg[p];
               ev.last = ((fired >> (p + 1)) == '0);
               pending_events.push_back(ev);
            end
         end
      end
   endfunction

   always @(posedge clock) begin
      pin_event_type want;
      if (reset) begin
         enabled_cfg <= '0;
         active_low_cfg <= '0;
         button_cfg <= '0;
         debounce_cfg <= mptd_pkg::DEBOUNCE_RESET;
         raw_state = '0;
         stable_state = '0;
         for (int p = 0; p < mptd_pkg::PIN_COUNT; p++)
            changed_at[p] = '0;
         pending_events.delete();
         events_outstanding <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_events.size() == 0) begin
               report_mismatch($sformatf("event on pin %0d with none expected",
                                         rsp_event_pin));
            end else begin
               want = pending_events.pop_front();
               if (rsp_event_pin !== want.pin)
                  report_mismatch($sformatf("event_pin %0d, expected %0d",
                                            rsp_event_pin, want.pin));
               if (rsp_event_active !== want.active)
                  report_mismatch($sformatf("pin %0d event_active %b, expected %b",
                                            want.pin, rsp_event_active, want.active));
               if (rsp_is_button !== want.button)
                  report_mismatch($sformatf("pin %0d is_button %b, expected %b",
                                            want.pin, rsp_is_button, want.button));
               if (rsp_last !== want.last)
                  report_mismatch($sformatf("pin %0d last %b, expected %b",
                                            want.pin, rsp_last, want.last));
            end
         end
         if (req_valid && !req_stall)
            debounce_sample(req_action, req_pin_levels, req_now_ms, req_arm_mask);
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (mptd_pkg::csr_reg_type'(csr_paddr[3:2]))
               mptd_pkg::CSR_ENABLED:
                  enabled_cfg <= csr_pwdata[mptd_pkg::PIN_COUNT-1:0];
               mptd_pkg::CSR_ACTIVE_LOW:
                  active_low_cfg <= csr_pwdata[mptd_pkg::PIN_COUNT-1:0];
               mptd_pkg::CSR_BUTTON:
                  button_cfg <= csr_pwdata[mptd_pkg::PIN_COUNT-1:0];
               mptd_pkg::CSR_DEBOUNCE:
                  debounce_cfg <= csr_pwdata[mptd_pkg::CFG_BITS-1:0];
               default: ;
            endcase
         end
         events_outstanding <= pending_events.size();
      end
   end

endmodule

/* verif/testbench.sv */
// ----------------------------------------------------------------------------
// Multi-pin time debouncer testbench
// Drives directed and random pin samples through the debouncer under several
// register settings, with random request gaps and response stalls and one
// long response hold-off, while the event checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench;

   localparam int QUIET_LIMIT = 2000;
   localparam int LONG_HOLD   = 150;

   logic                               clock;
   logic                               reset;
   logic                               req_valid;
   logic                               req_stall;
   logic                               req_action;
   logic [15:0]                        req_pin_levels;
   logic [31:0]                        req_now_ms;
   logic [15:0]                        req_arm_mask;
   logic                               rsp_valid;
   logic                               rsp_stall;
   logic [3:0]                         rsp_event_pin;
   logic                               rsp_event_active;
   logic                               rsp_is_button;
   logic                               rsp_last;
   logic                               csr_psel;
   logic                               csr_penable;
   logic                               csr_pwrite;
   logic [mptd_pkg::CSR_ADDR_BITS-1:0] csr_paddr;
   logic [mptd_pkg::CSR_DATA_BITS-1:0] csr_pwdata;
   logic [mptd_pkg::CSR_DATA_BITS-1:0] csr_prdata;
   logic                               csr_pready;

   int          mismatch_count;
   int          events_outstanding;
   int          quiet_cycles;
   int          holds_asked;
   int          holds_served;
   bit          idle_on;
   logic [15:0] settle_ms;

   multi_pin_time_debouncer dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_action       (req_action),
      .req_pin_levels   (req_pin_levels),
      .req_now_ms       (req_now_ms),
      .req_arm_mask     (req_arm_mask),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_event_pin    (rsp_event_pin),
      .rsp_event_active (rsp_event_active),
      .rsp_is_button    (rsp_is_button),
      .rsp_last         (rsp_last),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   debounce_event_checker event_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_action         (req_action),
      .req_pin_levels     (req_pin_levels),
      .req_now_ms         (req_now_ms),
      .req_arm_mask       (req_arm_mask),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_event_pin      (rsp_event_pin),
      .rsp_event_active   (rsp_event_active),
      .rsp_is_button      (rsp_is_button),
      .rsp_last           (rsp_last),
      .csr_psel           (csr_psel),
      .csr_penable        (csr_penable),
      .csr_pwrite         (csr_pwrite),
      .csr_paddr          (csr_paddr),
      .csr_pwdata         (csr_pwdata),
      .csr_pready         (csr_pready),
      .mismatch_count     (mismatch_count),
      .events_outstanding (events_outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Ends the run when nothing moves on any port for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_psel && csr_penable))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
         $display("multi_pin_time_debouncer test failed");
         $finish;
      end
   end

   // Response side: a random hold-off before each event while idle_on is set, or
   // a long one when the stimulus asks for it.
   initial begin : response_side
      int hold;
      rsp_stall <= 1'b0;
      wait (reset === 1'b0);
      @(posedge clock);
      forever begin
         if (holds_served < holds_asked) begin
            hold = LONG_HOLD;
            holds_served++;
         end else begin
            hold = idle_on ? $urandom_range(0, 8) : 0;
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (rsp_valid !== 1'b1);
      end
   end

   task automatic send_sample(input logic action, input logic [15:0] levels,
                              input logic [31:0] now, input logic [15:0] arm);
      int gap;
      gap = idle_on ? $urandom_range(0, 8) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= action;
      req_pin_levels <= levels;
      req_now_ms <= now;
      req_arm_mask <= arm;
      do @(posedge clock); while (req_stall);
   endtask

   // Waits until every predicted event has come out and the pipeline is empty.
   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(negedge clock); while (events_outstanding != 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_register(input mptd_pkg::csr_reg_type which,
                                 input logic [15:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {which, 2'b00};
      csr_pwdata <= {16'd0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic configure(input logic [15:0] enabled, input logic [15:0] active_low,
                            input logic [15:0] button, input logic [15:0] debounce);
      wait_idle();
      write_register(mptd_pkg::CSR_ENABLED, enabled);
      write_register(mptd_pkg::CSR_ACTIVE_LOW, active_low);
      write_register(mptd_pkg::CSR_BUTTON, button);
      write_register(mptd_pkg::CSR_DEBOUNCE, debounce);
      settle_ms = debounce;
   endtask

   // Pins bounce a few bits at a time while the clock advances, mostly in small
   // steps and now and then past the debounce time; arms and noise are mixed in.
   task automatic random_samples(input int count);
      logic [15:0] levels;
      logic [31:0] stamp;
      int pick;
      levels = 16'($urandom);
      stamp = $urandom;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 19);
         if (pick == 0) begin
            send_sample(mptd_pkg::ACT_ARM, levels, stamp, 16'($urandom));
         end else if (pick == 1) begin
            send_sample(mptd_pkg::ACT_DEBOUNCE, 16'($urandom), $urandom, 16'($urandom));
         end else begin
            if (pick < 8)
               levels = levels ^ 16'($urandom & $urandom);
            if (pick < 5)
               stamp = stamp + settle_ms + 1;
            else
               stamp = stamp + $urandom_range(0, settle_ms / 4 + 2);
            send_sample(mptd_pkg::ACT_DEBOUNCE, levels, stamp, 16'($urandom));
         end
      end
   endtask

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_action <= mptd_pkg::ACT_DEBOUNCE;
      req_pin_levels <= '0;
      req_now_ms <= '0;
      req_arm_mask <= '0;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;
      holds_asked = 0;
      holds_served = 0;
      idle_on = 1'b1;
      settle_ms = mptd_pkg::DEBOUNCE_RESET;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Nothing enabled: samples are ignored, but an arm still loads pins.
      configure(16'h0000, 16'h0000, 16'h0000, mptd_pkg::DEBOUNCE_RESET);
      send_sample(mptd_pkg::ACT_DEBOUNCE, 16'hFFFF, 32'd10, 16'h0000);
      send_sample(mptd_pkg::ACT_ARM, 16'h00F0, 32'd20, 16'h00FF);

      // Zero debounce time: every change is an event in the same request.
      configure(16'hFFFF, 16'h0000, 16'hAAAA, 16'd0);
      send_sample(mptd_pkg::ACT_DEBOUNCE, 16'hFFFF, 32'd0, 16'h0000);
      send_sample(mptd_pkg::ACT_DEBOUNCE, 16'h0000, 32'd0, 16'h0000);
      send_sample(mptd_pkg::ACT_DEBOUNCE, 16'h8001, 32'd1, 16'h0000);
      send_sample(mptd_pkg::ACT_DEBOUNCE, 16'h8001, 32'd2, 16'hFFFF);

      // Longest debounce time, with the elapsed time wrapping through zero.
      configure(16'hFFFF, 16'hFFFF, 16'h5555, 16'hFFFF);
      send_sample(mptd_pkg::ACT_ARM, 16'hFFFF, 32'hFFFF_FFF0, 16'hFFFF);
      send_sample(mptd_pkg::ACT_DEBOUNCE, 16'h0000, 32'hFFFF_FFF8, 16'h0000);
      send_sample(mptd_pkg::ACT_DEBOUNCE, 16'h0000, 32'h0000_FFF6, 16'h0000);
      send_sample(mptd_pkg::ACT_DEBOUNCE, 16'h0000, 32'h0000_FFF7, 16'h0000);
      send_sample(mptd_pkg::ACT_DEBOUNCE, 16'hFFFF, 32'hFFFF_FFFF, 16'h0000);

      // Some pins disabled, mixed polarity and kinds.
      configure(16'h5A5A, 16'h0F0F, 16'h3C3C, 16'd50);
      send_sample(mptd_pkg::ACT_DEBOUNCE, 16'h0000, 32'd100, 16'h0000);
      send_sample(mptd_pkg::ACT_DEBOUNCE, 16'hFFFF, 32'd120, 16'h0000);
      send_sample(mptd_pkg::ACT_DEBOUNCE, 16'hFFFF, 32'd170, 16'h0000);
      send_sample(mptd_pkg::ACT_DEBOUNCE, 16'hFFFF, 32'd169, 16'h0000);
      send_sample(mptd_pkg::ACT_DEBOUNCE, 16'h1234, 32'd300, 16'h0000);
      send_sample(mptd_pkg::ACT_DEBOUNCE, 16'h1234, 32'd349, 16'h0000);
      send_sample(mptd_pkg::ACT_DEBOUNCE, 16'h1234, 32'd350, 16'h0000);

      // Back-to-back requests while the response side holds off for a long
      // stretch, so the event queue fills and the request side stalls.
      idle_on = 1'b0;
      configure(16'hFFFF, 16'($urandom), 16'($urandom), 16'd0);
      holds_asked++;
      random_samples(50);

      idle_on = 1'b1;
      configure(16'($urandom) | 16'h0101, 16'($urandom), 16'($urandom),
                16'($urandom_range(1, 20)));
      random_samples(50);

      configure(16'($urandom), 16'($urandom), 16'($urandom), 16'hFFFF);
      random_samples(45);

      idle_on = 1'b0;
      configure(16'hFFFF, 16'hFFFF, 16'h0000, 16'($urandom_range(0, 65535)));
      random_samples(45);

      idle_on = 1'b1;
      configure(16'($urandom) | 16'h8000, 16'h0000, 16'hFFFF, 16'd5);
      random_samples(50);

      wait_idle();
      if (mismatch_count == 0)
         $display("multi_pin_time_debouncer test passed");
      else
         $display("multi_pin_time_debouncer test failed");
      $finish;
   end

endmodule

/* multi_pin_time_debouncer.f */
sv/mptd_pkg.sv
sv/mptd_pin_eval.sv
sv/mptd_event_queue.sv
sv/multi_pin_time_debouncer.sv
sv/mptd_checker.sv
verif/debounce_event_checker.sv
verif/testbench.sv
